### design/bta_pkg.sv
// Shared types, constants and helpers for the binary to ASCII converter.
package bta_pkg;

  localparam int unsigned ValueW      = 64;
  localparam int unsigned CharW       = 8;
  localparam int unsigned DigitW      = 4;
  localparam int unsigned NumDigits   = 20;
  localparam int unsigned BitsPerStep = 4;
  localparam int unsigned ConvSteps   = ValueW / BitsPerStep;
  localparam int unsigned StepW       = $clog2(ConvSteps);
  localparam int unsigned DigIdxW     = $clog2(NumDigits);

  localparam int unsigned InQueueDepthDef  = 2;
  localparam int unsigned OutQueueDepthDef = 2;

  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChUpperA = 8'h41;
  localparam logic [CharW-1:0] ChLowerX = 8'h78;

  typedef logic [NumDigits-1:0][DigitW-1:0] digits_t;

  // Classified input beat handed from the front to the back.
  typedef struct packed {
    logic              hex;
    logic              prefix;  // "0x" wanted: hex, flag set, value nonzero
    logic [ValueW-1:0] value;
  } item_t;

  // One output character beat.
  typedef struct packed {
    logic             last;
    logic [CharW-1:0] char_code;
  } res_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkConv,
    BkScan,
    BkPfx0,
    BkPfx1,
    BkEmit
  } back_state_e;

  // One double-dabble step: correct every BCD digit, then shift in one bit.
  function automatic digits_t dabble(input digits_t bcd, input logic b);
    digits_t adj;
    logic [NumDigits*DigitW-1:0] flat;
    for (int i = 0; i < NumDigits; i++) begin
      adj[i] = (bcd[i] >= DigitW'(5)) ? bcd[i] + DigitW'(3) : bcd[i];
    end
    flat = adj;
    flat = {flat[NumDigits*DigitW-2:0], b};
    return digits_t'(flat);
  endfunction

  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    if (d < DigitW'(10)) begin
      c = ChZero + CharW'(d);
    end else begin
      c = ChUpperA + CharW'(d) - CharW'(10);
    end
    return c;
  endfunction

endpackage

### design/binary_to_ascii_dec_hex_top.sv
// Binary to ASCII text converter (decimal or hex), top level.
// Decimal: the back end pops the number, runs 4-bit-per-cycle double dabble, does one
// leading-zero scan, then emits the characters.
// Hex: pop, scan, then the "0x" prefix if wanted and the digits. One character per cycle
// while the result queue has room; queues on both sides let input and output stall
// independently. Async active-low reset empties both.
module binary_to_ascii_dec_hex_top #(
  parameter int unsigned InQueueDepth  = bta_pkg::InQueueDepthDef,
  parameter int unsigned OutQueueDepth = bta_pkg::OutQueueDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic                      func_i,
  input  logic [bta_pkg::ValueW-1:0] value_i,
  input  logic                      show_prefix_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [bta_pkg::CharW-1:0] char_code_o,
  output logic                      last_o
);
  import bta_pkg::*;

  item_t item;
  logic  item_empty;
  logic  item_pop;

  bta_front #(
    .QueueDepth (InQueueDepth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .func_i        (func_i),
    .value_i       (value_i),
    .show_prefix_i (show_prefix_i),
    .item_o        (item),
    .item_empty_o  (item_empty),
    .item_pop_i    (item_pop)
  );

  bta_back #(
    .QueueDepth (OutQueueDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_empty_i (item_empty),
    .item_pop_o   (item_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .char_code_o  (char_code_o),
    .last_o       (last_o)
  );

endmodule

### design/bta_fifo.sv
// Small generic register queue used on both sides of the converter.
module bta_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### design/bta_front.sv
// Front end: takes input beats, classifies them and queues them for the back end.
module bta_front #(
  parameter int unsigned QueueDepth = bta_pkg::InQueueDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic                      func_i,
  input  logic [bta_pkg::ValueW-1:0] value_i,
  input  logic                      show_prefix_i,
  output bta_pkg::item_t            item_o,
  output logic                      item_empty_o,
  input  logic                      item_pop_i
);
  import bta_pkg::*;

  item_t                 item_in;
  logic [$bits(item_t)-1:0] item_raw;

  always_comb begin
    item_in.hex    = func_i;
    // prefix only for nonzero hex values
    item_in.prefix = func_i && show_prefix_i && (value_i != '0);
    item_in.value  = value_i;
  end

  bta_fifo #(
    .Width ($bits(item_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (item_in),
    .full_o  (full_o),
    .pop_i   (item_pop_i),
    .data_o  (item_raw),
    .empty_o (item_empty_o)
  );

  assign item_o = item_t'(item_raw);

endmodule

### design/bta_back.sv
// Back end: BCD conversion, leading-zero scan and character serializer.
module bta_back #(
  parameter int unsigned QueueDepth = bta_pkg::OutQueueDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bta_pkg::item_t            item_i,
  input  logic                      item_empty_i,
  output logic                      item_pop_o,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic [bta_pkg::CharW-1:0] char_code_o,
  output logic                      last_o
);
  import bta_pkg::*;

  back_state_e          state_q, state_d;
  logic                 pfx_q, pfx_d;
  logic [ValueW-1:0]    val_q, val_d;
  digits_t              dig_q, dig_d;
  logic [StepW-1:0]     step_q, step_d;
  logic [DigIdxW-1:0]   idx_q, idx_d;
  logic [DigIdxW-1:0]   msd;
  res_t                 res;
  logic                 res_push, res_full;
  logic [$bits(res_t)-1:0] res_raw;
  res_t                 res_out;

  // highest nonzero digit, zero when all digits are zero
  always_comb begin
    msd = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (dig_q[i] != '0) begin
        msd = DigIdxW'(i);
      end
    end
  end

  always_comb begin
    digits_t     acc;
    logic [ValueW-1:0] v;
    state_d    = state_q;
    pfx_d      = pfx_q;
    val_d      = val_q;
    dig_d      = dig_q;
    step_d     = step_q;
    idx_d      = idx_q;
    item_pop_o = 1'b0;
    res_push   = 1'b0;
    res        = '0;
    acc        = dig_q;
    v          = val_q;
    unique case (state_q)
      BkIdle: begin
        if (!item_empty_i) begin
          item_pop_o = 1'b1;
          pfx_d      = item_i.prefix;
          val_d      = item_i.value;
          step_d     = '0;
          if (item_i.hex) begin
            dig_d   = digits_t'({{(NumDigits*DigitW-ValueW){1'b0}}, item_i.value});
            state_d = BkScan;
          end else begin
            dig_d   = '0;
            state_d = BkConv;
          end
        end
      end
      BkConv: begin
        for (int k = 0; k < BitsPerStep; k++) begin
          acc = dabble(acc, v[ValueW-1]);
          v   = v << 1;
        end
        dig_d  = acc;
        val_d  = v;
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(ConvSteps - 1)) begin
          state_d = BkScan;
        end
      end
      BkScan: begin
        idx_d   = msd;
        state_d = pfx_q ? BkPfx0 : BkEmit;
      end
      BkPfx0: begin
        res.char_code = ChZero;
        if (!res_full) begin
          res_push = 1'b1;
          state_d  = BkPfx1;
        end
      end
      BkPfx1: begin
        res.char_code = ChLowerX;
        if (!res_full) begin
          res_push = 1'b1;
          state_d  = BkEmit;
        end
      end
      BkEmit: begin
        res.char_code = digit_char(dig_q[idx_q]);
        res.last      = (idx_q == '0);
        if (!res_full) begin
          res_push = 1'b1;
          if (idx_q == '0) begin
            state_d = BkIdle;
          end else begin
            idx_d = idx_q - DigIdxW'(1);
          end
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pfx_q  <= pfx_d;
    val_q  <= val_d;
    dig_q  <= dig_d;
    step_q <= step_d;
    idx_q  <= idx_d;
  end

  bta_fifo #(
    .Width ($bits(res_t)),
    .Depth (QueueDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (res_raw),
    .empty_o (empty_o)
  );

  assign res_out     = res_t'(res_raw);
  assign char_code_o = res_out.char_code;
  assign last_o      = res_out.last;

  // every value bit has been shifted into the BCD digits at the end of conversion
  a_conv_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkConv && step_q == StepW'(ConvSteps - 1)) |=> (val_q == '0))
    else $error("bta_back: value bits left after conversion");

  // hex beats skip the BCD conversion
  a_hex_skips_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkIdle && item_pop_o && item_i.hex) |=> (state_q == BkScan))
    else $error("bta_back: hex beat entered conversion");

  // the serializer never stalls with a beat lost
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("bta_back: push into full result queue");

  // the digit index stays within the digits while emitting
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkEmit) |-> (idx_q < DigIdxW'(NumDigits)))
    else $error("bta_back: digit index out of range");

endmodule
